FILE: rtl/nsf_pkg.sv
`default_nettype none
package nsf_pkg;

  localparam int MAX_LINE_LEN_DEF = 128;
  localparam int MAX_FIELDS_DEF   = 32;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2a;
  localparam logic [7:0] CHAR_COMMA  = 8'h2c;
  localparam logic [7:0] CHAR_CR     = 8'h0d;
  localparam logic [7:0] CHAR_LF     = 8'h0a;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_VALID     = 2'd1,
    EV_CKSUM_ERR = 2'd2,
    EV_OVERFLOW  = 2'd3
  } event_t;

  // per-sentence framing state, bit4 of a digit marks a non-hex character
  typedef struct packed {
    logic       collecting;
    logic [7:0] body_length;
    logic [7:0] running_xor;
    logic [7:0] xor_at_last_star;
    logic       star_seen;
    logic [1:0] chars_after_star;
    logic [4:0] high_digit;
    logic [4:0] low_digit;
    logic [7:0] comma_count;
    logic [7:0] commas_at_last_star;
  } frame_state_t;

  typedef struct packed {
    event_t     event_res;
    logic       stored;
    logic [6:0] position;
    logic [5:0] field_count;
    logic [7:0] computed_sum;
  } step_res_t;

  function automatic logic [4:0] hex_code(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h61 + 8'd10);
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/nsf_rx_if.sv
`default_nettype none
interface nsf_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface
`default_nettype wire

FILE: rtl/nsf_res_if.sv
`default_nettype none
interface nsf_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_res;
  logic        stored;
  logic [6:0]  position;
  logic [5:0]  field_count;
  logic [7:0]  computed_sum;
  logic [31:0] valid_total;
  logic [31:0] checksum_error_total;
  logic [31:0] overflow_total;

  modport source (
    output valid, output event_res, output stored, output position,
    output field_count, output computed_sum, output valid_total,
    output checksum_error_total, output overflow_total, input ready
  );
  modport sink (
    input valid, input event_res, input stored, input position,
    input field_count, input computed_sum, input valid_total,
    input checksum_error_total, input overflow_total, output ready
  );
endinterface
`default_nettype wire

FILE: rtl/nsf_step.sv
`default_nettype none
module nsf_step
  import nsf_pkg::*;
#(
  parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF,
  parameter int MAX_FIELDS   = MAX_FIELDS_DEF
) (
  input  wire frame_state_t cur,
  input  wire logic [7:0]   rx_byte,
  output frame_state_t      nxt,
  output step_res_t         res
);

  localparam logic [7:0] LEN_LIMIT   = 8'(MAX_LINE_LEN);
  localparam logic [8:0] FIELD_LIMIT = 9'(MAX_FIELDS);

  logic       sum_ok;
  logic [8:0] fields;

  always_comb begin
    nxt    = cur;
    res    = '0;
    sum_ok = 1'b0;
    fields = 9'({1'b0, cur.commas_at_last_star}) + 9'd1;
    if (fields > FIELD_LIMIT) fields = FIELD_LIMIT;

    if (rx_byte == CHAR_DOLLAR) begin
      nxt            = '0;
      nxt.collecting = 1'b1;
    end else if (cur.collecting) begin
      if (rx_byte == CHAR_CR || rx_byte == CHAR_LF) begin
        nxt = '0;
        res.computed_sum = cur.star_seen ? cur.xor_at_last_star : cur.running_xor;
        sum_ok = cur.star_seen && cur.chars_after_star >= 2'd2 &&
                 !cur.high_digit[4] && !cur.low_digit[4] &&
                 cur.xor_at_last_star == {cur.high_digit[3:0], cur.low_digit[3:0]};
        if (sum_ok) begin
          res.event_res   = EV_VALID;
          res.field_count = fields[5:0];
        end else begin
          res.event_res = EV_CKSUM_ERR;
        end
      end else if (cur.body_length >= LEN_LIMIT) begin
        nxt           = '0;
        res.event_res = EV_OVERFLOW;
      end else begin
        res.stored      = 1'b1;
        res.position    = cur.body_length[6:0];
        nxt.body_length = cur.body_length + 8'd1;
        if (rx_byte == CHAR_STAR) begin
          nxt.star_seen           = 1'b1;
          nxt.xor_at_last_star    = cur.running_xor;
          nxt.commas_at_last_star = cur.comma_count;
          nxt.chars_after_star    = 2'd0;
          nxt.high_digit          = 5'd0;
          nxt.low_digit           = 5'd0;
        end else if (cur.star_seen) begin
          if (cur.chars_after_star == 2'd0) nxt.high_digit = hex_code(rx_byte);
          else if (cur.chars_after_star == 2'd1) nxt.low_digit = hex_code(rx_byte);
          if (cur.chars_after_star != 2'd3) nxt.chars_after_star = cur.chars_after_star + 2'd1;
        end
        if (rx_byte == CHAR_COMMA && cur.comma_count != 8'hff) begin
          nxt.comma_count = cur.comma_count + 8'd1;
        end
        nxt.running_xor = cur.running_xor ^ rx_byte;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/nmea_sentence_framer_top.sv
// NMEA 0183 sentence framer: takes one received byte per transaction and gives
// exactly one result per byte, one byte per cycle sustained unless stalled. The
// framing step is a single pass of logic from the held sentence state to the
// result register; a new byte is taken whenever the result register is empty
// or being taken. A '$' starts or restarts a sentence, CR or LF ends it, and
// the result carries the event, the XOR of the body up to the last '*' if any,
// and for a valid sentence the field count. The three 32-bit totals are the
// counts after the byte of that result and wrap. No startup delay after reset.
`default_nettype none
module nmea_sentence_framer_top
  import nsf_pkg::*;
#(
  parameter int MAX_LINE_LEN = MAX_LINE_LEN_DEF,
  parameter int MAX_FIELDS   = MAX_FIELDS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  nsf_rx_if.sink    rx,
  nsf_res_if.source result
);

  frame_state_t st;
  frame_state_t st_next;
  step_res_t    step_res;
  step_res_t    res;
  logic         res_valid;
  logic [31:0]  valid_counter;
  logic [31:0]  checksum_error_counter;
  logic [31:0]  overflow_counter;
  logic         accept;

  nsf_step #(
    .MAX_LINE_LEN(MAX_LINE_LEN),
    .MAX_FIELDS  (MAX_FIELDS)
  ) u_step (
    .cur    (st),
    .rx_byte(rx.rx_byte),
    .nxt    (st_next),
    .res    (step_res)
  );

  assign rx.ready = !res_valid || result.ready;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st                     <= '0;
      res_valid              <= 1'b0;
      valid_counter          <= '0;
      checksum_error_counter <= '0;
      overflow_counter       <= '0;
    end else if (accept) begin
      st        <= st_next;
      res_valid <= 1'b1;
      case (step_res.event_res)
        EV_VALID:     valid_counter <= valid_counter + 32'd1;
        EV_CKSUM_ERR: checksum_error_counter <= checksum_error_counter + 32'd1;
        EV_OVERFLOW:  overflow_counter <= overflow_counter + 32'd1;
        default:      ;
      endcase
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (accept) res <= step_res;
  end

  // counters only move on the transaction that also loads the result register
  assign result.valid                = res_valid;
  assign result.event_res            = res.event_res;
  assign result.stored               = res.stored;
  assign result.position             = res.position;
  assign result.field_count          = res.field_count;
  assign result.computed_sum         = res.computed_sum;
  assign result.valid_total          = valid_counter;
  assign result.checksum_error_total = checksum_error_counter;
  assign result.overflow_total       = overflow_counter;

endmodule
`default_nettype wire

FILE: test/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nsf_pkg::*;

  localparam int LINE_LIMIT     = MAX_LINE_LEN_DEF;
  localparam int FIELD_LIMIT    = MAX_FIELDS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 150;
  localparam int STREAM_TARGET  = 640;

  typedef struct packed {
    event_t      ev;
    logic        stored;
    logic [6:0]  position;
    logic [5:0]  fields;
    logic [7:0]  sum;
    logic [31:0] valid_total;
    logic [31:0] cksum_total;
    logic [31:0] ovf_total;
  } framer_result_t;

  logic clk = 1'b0;
  logic rst;

  nsf_rx_if  rx_ch ();
  nsf_res_if res_ch ();

  nmea_sentence_framer_top dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .result (res_ch)
  );

  always #10 clk = ~clk;

  logic [7:0]     byte_stream[$];
  framer_result_t predicted_results[$];

  // sentence state tracked alongside the block
  logic        in_sentence;
  logic [7:0]  body_len;
  logic [7:0]  xor_all;
  logic [7:0]  xor_before_star;
  logic        have_star;
  logic [1:0]  after_star_cnt;
  logic [4:0]  hi_nib;
  logic [4:0]  lo_nib;
  logic [7:0]  commas;
  logic [7:0]  commas_before_star;
  logic [31:0] n_valid;
  logic [31:0] n_cksum_err;
  logic [31:0] n_overflow;

  int mismatches    = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int idle_cycles   = 0;
  int hold_requests = 0;
  int holds_done    = 0;
  int gap_left      = 0;
  int stall_left    = 0;
  bit source_quiet  = 1'b0;
  bit sink_quiet    = 1'b0;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      return {1'b0, c[3:0] + 4'd9};
    return 5'h10;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input logic lower);
    if (nib < 4'd10) return 8'h30 + {4'h0, nib};
    return (lower ? 8'h61 : 8'h41) + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void clear_sentence();
    body_len           = '0;
    xor_all            = '0;
    xor_before_star    = '0;
    have_star          = 1'b0;
    after_star_cnt     = '0;
    hi_nib             = '0;
    lo_nib             = '0;
    commas             = '0;
    commas_before_star = '0;
  endfunction

  task automatic frame_byte(input logic [7:0] b);
    framer_result_t r;
    int n;
    r = '0;
    if (b == CHAR_DOLLAR) begin
      in_sentence = 1'b1;
      clear_sentence();
    end else if (in_sentence) begin
      if (b == CHAR_CR || b == CHAR_LF) begin
        in_sentence = 1'b0;
        r.sum = have_star ? xor_before_star : xor_all;
        if (have_star && after_star_cnt >= 2'd2 && !hi_nib[4] && !lo_nib[4] &&
            xor_before_star == {hi_nib[3:0], lo_nib[3:0]}) begin
          n = int'(commas_before_star) + 1;
          if (n > FIELD_LIMIT) n = FIELD_LIMIT;
          r.ev     = EV_VALID;
          r.fields = 6'(n);
          n_valid++;
        end else begin
          r.ev = EV_CKSUM_ERR;
          n_cksum_err++;
        end
        clear_sentence();
      end else if (int'(body_len) >= LINE_LIMIT) begin
        in_sentence = 1'b0;
        r.ev = EV_OVERFLOW;
        n_overflow++;
        clear_sentence();
      end else begin
        r.stored   = 1'b1;
        r.position = body_len[6:0];
        body_len++;
        if (b == CHAR_STAR) begin
          have_star          = 1'b1;
          xor_before_star    = xor_all;
          commas_before_star = commas;
          after_star_cnt     = '0;
          hi_nib             = '0;
          lo_nib             = '0;
        end else if (have_star) begin
          if (after_star_cnt == 2'd0) hi_nib = hex_value(b);
          else if (after_star_cnt == 2'd1) lo_nib = hex_value(b);
          if (after_star_cnt != 2'd3) after_star_cnt++;
        end
        if (b == CHAR_COMMA && commas != 8'hff) commas++;
        xor_all ^= b;
      end
    end
    r.valid_total = n_valid;
    r.cksum_total = n_cksum_err;
    r.ovf_total   = n_overflow;
    predicted_results.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at result %0d: got %0h, expected %0h",
               what, results_seen, got, want);
  endtask

  task automatic check_result();
    framer_result_t want;
    results_seen++;
    if (predicted_results.size() == 0) begin
      report_mismatch("transaction with nothing pending", 32'(res_ch.event_res), 0);
      return;
    end
    want = predicted_results.pop_front();
    if (res_ch.event_res !== want.ev)
      report_mismatch("event_res", 32'(res_ch.event_res), 32'(want.ev));
    if (res_ch.stored !== want.stored)
      report_mismatch("stored", 32'(res_ch.stored), 32'(want.stored));
    if (res_ch.position !== want.position)
      report_mismatch("position", 32'(res_ch.position), 32'(want.position));
    if (res_ch.field_count !== want.fields)
      report_mismatch("field_count", 32'(res_ch.field_count), 32'(want.fields));
    if (res_ch.computed_sum !== want.sum)
      report_mismatch("computed_sum", 32'(res_ch.computed_sum), 32'(want.sum));
    if (res_ch.valid_total !== want.valid_total)
      report_mismatch("valid_total", res_ch.valid_total, want.valid_total);
    if (res_ch.checksum_error_total !== want.cksum_total)
      report_mismatch("checksum_error_total", res_ch.checksum_error_total, want.cksum_total);
    if (res_ch.overflow_total !== want.ovf_total)
      report_mismatch("overflow_total", res_ch.overflow_total, want.ovf_total);
  endtask

  // stimulus helpers

  function automatic logic [7:0] body_char(input logic heavy);
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (heavy && r < 40) return CHAR_COMMA;
    if (r < 45) return 8'($urandom_range(8'h30, 8'h5a));
    if (r < 60) return CHAR_COMMA;
    if (r < 63) return CHAR_STAR;
    c = 8'($urandom_range(0, 255));
    while (c == CHAR_DOLLAR || c == CHAR_CR || c == CHAR_LF) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] h;
    c = 8'($urandom_range(0, 255));
    h = hex_value(c);
    while (!h[4] || c == CHAR_DOLLAR || c == CHAR_CR || c == CHAR_LF ||
           c == CHAR_STAR) begin
      c = 8'($urandom_range(0, 255));
      h = hex_value(c);
    end
    return c;
  endfunction

  // one sentence; forced_len < 0 picks a random body length
  task automatic add_sentence(input int forced_len);
    int body_n, r, extra_n;
    logic [7:0] x, c;
    logic lower, heavy;
    x     = '0;
    lower = 1'($urandom_range(0, 1));
    heavy = ($urandom_range(0, 9) == 0);
    r     = $urandom_range(0, 99);
    if (forced_len >= 0) body_n = forced_len;
    else if (heavy) body_n = $urandom_range(30, 90);
    else if (r < 80) body_n = $urandom_range(0, 20);
    else if (r < 92) body_n = $urandom_range(21, 124);
    else body_n = $urandom_range(125, 140);
    byte_stream.push_back(CHAR_DOLLAR);
    for (int i = 0; i < body_n; i++) begin
      c = body_char(heavy);
      byte_stream.push_back(c);
      x ^= c;
    end
    r = $urandom_range(0, 99);
    // broken off, the next dollar restarts
    if (r < 6) return;
    if (r < 88 || r >= 92) byte_stream.push_back(CHAR_STAR);
    if (r < 70 || r >= 92) begin
      if (r >= 60 && r < 70) x ^= 8'(1 << $urandom_range(0, 7));
      byte_stream.push_back(hex_char(x[7:4], lower));
      byte_stream.push_back(hex_char(x[3:0], lower));
    end else if (r < 78) begin
      if ($urandom_range(0, 1)) begin
        byte_stream.push_back(non_hex_char());
        byte_stream.push_back(hex_char(x[3:0], lower));
      end else begin
        byte_stream.push_back(hex_char(x[7:4], lower));
        byte_stream.push_back(non_hex_char());
      end
    end else if (r < 84) begin
      byte_stream.push_back(hex_char(x[7:4], lower));
    end
    if (r >= 92) begin
      extra_n = $urandom_range(1, 4);
      for (int i = 0; i < extra_n; i++) begin
        c = body_char(1'b0);
        while (c == CHAR_STAR) c = body_char(1'b0);
        byte_stream.push_back(c);
      end
    end
    byte_stream.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int pick_stall(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 80) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= 8'h00;
    end else begin
      if (rx_ch.valid && rx_ch.ready) begin
        frame_byte(rx_ch.rx_byte);
        bytes_sent++;
      end
      if (!rx_ch.valid || rx_ch.ready) begin
        if ($urandom_range(0, 299) == 0) source_quiet = !source_quiet;
        if (gap_left > 0) begin
          gap_left--;
          rx_ch.valid <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= byte_stream.pop_front();
          gap_left = pick_gap(source_quiet);
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_result();
      if ($urandom_range(0, 299) == 0) sink_quiet = !sink_quiet;
      if (hold_requests != holds_done) begin
        holds_done++;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
        stall_left = pick_stall(sink_quiet);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int noise_n;
    logic [7:0] c;
    rst           = 1'b1;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    res_ch.ready  = 1'b0;
    in_sentence   = 1'b0;
    clear_sentence();
    n_valid     = '0;
    n_cksum_err = '0;
    n_overflow  = '0;

    // idle bytes, including a terminator with no sentence open
    byte_stream = '{8'h00, 8'hff, CHAR_LF};
    // empty body with checksum 00
    byte_stream = {byte_stream, CHAR_DOLLAR, CHAR_STAR, "0", "0", CHAR_CR};
    // comma and NUL, lower-case digits
    byte_stream = {byte_stream, CHAR_DOLLAR, CHAR_COMMA, 8'h00, CHAR_STAR, "2", "c", CHAR_LF};
    // non-hex digit
    byte_stream = {byte_stream, CHAR_DOLLAR, CHAR_STAR, "0", "G", CHAR_CR};
    // no checksum at all
    byte_stream = {byte_stream, CHAR_DOLLAR, CHAR_CR};
    // restart inside a sentence
    byte_stream = {byte_stream, CHAR_DOLLAR, "Q", CHAR_DOLLAR, CHAR_STAR, "0", "0", CHAR_LF};

    add_sentence(200);
    add_sentence(125);
    while (byte_stream.size() < STREAM_TARGET) begin
      if ($urandom_range(0, 4) == 0) begin
        noise_n = $urandom_range(1, 6);
        for (int i = 0; i < noise_n; i++) begin
          c = 8'($urandom_range(0, 255));
          while (c == CHAR_DOLLAR) c = 8'($urandom_range(0, 255));
          byte_stream.push_back(c);
        end
      end
      add_sentence(-1);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // long receiver hold-off mid-stream so the input backs up
    wait (bytes_sent >= 300);
    hold_requests++;

    while (byte_stream.size() != 0 || rx_ch.valid || predicted_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);

    $display("testbench: %0d bytes sent, %0d results checked", bytes_sent, results_seen);
    $display("testbench: %0d valid sentences, %0d checksum errors, %0d overflow aborts",
             n_valid, n_cksum_err, n_overflow);
    if (mismatches == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire
